// ===== src/hbud_pkg.sv =====
// Shared constants and types for the HDLC byte-unstuffing deframer.
package hbud_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned COUNT_W  = LEN_W + 1;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0]  FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0]  ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0]  ESC_XOR   = 8'h20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = {LEN_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ESC  = 2'd1,
        ST_OVERSIZE = 2'd2
    } status_t;

    // One result transaction, as produced by the decode core.
    typedef struct packed {
        logic               produce;
        logic [BYTE_W-1:0]  payload_byte;
        logic               frame_end;
        status_t            frame_status;
        logic [LEN_W-1:0]   frame_length;
    } result_t;

endpackage

// ===== src/hbud_core.sv =====
// Frame state and byte-unstuffing decode for one line byte per step.
module hbud_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [hbud_pkg::BYTE_W-1:0]  line_byte,
    input  logic [hbud_pkg::LEN_W-1:0]   max_frame_len,
    output hbud_pkg::result_t            result
);

    logic                         in_frame_reg, in_frame_next;
    logic                         esc_reg, esc_next;
    logic [hbud_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [hbud_pkg::COUNT_W-1:0] max_ext;
    logic [hbud_pkg::BYTE_W-1:0]  data_byte;
    logic [hbud_pkg::LEN_W-1:0]   end_length;

    assign max_ext    = {1'b0, max_frame_len};
    assign data_byte  = esc_reg ? (line_byte ^ hbud_pkg::ESC_XOR) : line_byte;
    assign end_length = (count_reg < max_ext) ? count_reg[hbud_pkg::LEN_W-1:0]
                                              : max_frame_len;

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        result        = '0;
        result.frame_status = hbud_pkg::ST_OK;

        if (line_byte == hbud_pkg::FLAG_BYTE) begin
            if (!in_frame_reg) begin
                // opening flag
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = '0;
            end else begin
                result.produce      = 1'b1;
                result.frame_end    = 1'b1;
                result.frame_length = end_length;
                if (esc_reg) begin
                    result.frame_status = hbud_pkg::ST_BAD_ESC;
                end else if (count_reg > max_ext) begin
                    result.frame_status = hbud_pkg::ST_OVERSIZE;
                end
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                count_next    = '0;
            end
        end else if (in_frame_reg) begin
            if (line_byte == hbud_pkg::ESC_BYTE) begin
                if (esc_reg) begin
                    // double escape aborts the frame
                    result.produce      = 1'b1;
                    result.frame_end    = 1'b1;
                    result.frame_status = hbud_pkg::ST_BAD_ESC;
                    result.frame_length = end_length;
                    in_frame_next = 1'b0;
                    esc_next      = 1'b0;
                    count_next    = '0;
                end else begin
                    esc_next = 1'b1;
                end
            end else begin
                esc_next = 1'b0;
                if (count_reg != hbud_pkg::COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
                if (count_reg < max_ext) begin
                    result.produce      = 1'b1;
                    result.payload_byte = data_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
        end else if (step) begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== src/hdlc_byte_unstuff_deframer_top.sv =====
// HDLC async byte-unstuffing deframer: top level with input and result registers.
//
// Takes one raw line byte per s_ transaction and strips asynchronous HDLC
// framing: 0x7E flags open and close a frame, 0x7D escapes the next byte,
// which is XORed with 0x20. Bytes outside a frame are dropped. Each payload
// byte comes out as an m_ transaction with m_frame_end low, while fewer than
// max_frame_len bytes have been delivered; further bytes are dropped but
// still counted. A closing flag, an escaped flag or a double escape gives a
// frame-end transaction (m_frame_end high) with the delivered length and a
// status of ok (0), bad escape (1) or oversize (2). A byte moves through an
// input register and the result register, and one byte is taken every cycle;
// the input side stalls only when a byte would produce a result while the
// result register is still held by m_ready low. max_frame_len resets to 65535;
// the user is to write it through cfg_wr_en only while idle; the block does not enforce this.
module hdlc_byte_unstuff_deframer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [hbud_pkg::LEN_W-1:0]          cfg_wr_data,
    // line byte input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hbud_pkg::BYTE_W-1:0]         s_line_byte,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hbud_pkg::BYTE_W-1:0]         m_payload_byte,
    output logic                                m_frame_end,
    output logic [hbud_pkg::STATUS_W-1:0]       m_frame_status,
    output logic [hbud_pkg::LEN_W-1:0]          m_frame_length
);

    logic [hbud_pkg::LEN_W-1:0]  max_len_reg;

    // input register
    logic                        in_valid_reg;
    logic [hbud_pkg::BYTE_W-1:0] in_byte_reg;

    // result register
    logic                        out_valid_reg;
    hbud_pkg::result_t           out_reg;

    hbud_pkg::result_t           core_result;
    logic                        out_free;
    logic                        advance;

    // Result slot can take a new transaction if empty or draining this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // Byte in the input register is processed unless its result has no room.
    assign advance  = in_valid_reg && (!core_result.produce || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= hbud_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_line_byte;
        end
    end

    hbud_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .line_byte     (in_byte_reg),
        .max_frame_len (max_len_reg),
        .result        (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && core_result.produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_result.produce) begin
            out_reg <= core_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_frame_end    = out_reg.frame_end;
    assign m_frame_status = out_reg.frame_status;
    assign m_frame_length = out_reg.frame_length;

endmodule

// ===== src/hbud_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module hbud_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hbud_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [hbud_pkg::BYTE_W-1:0]   m_payload_byte,
    input  logic                          m_frame_end,
    input  logic [hbud_pkg::STATUS_W-1:0] m_frame_status,
    input  logic [hbud_pkg::LEN_W-1:0]    m_frame_length
);

    logic [hbud_pkg::LEN_W-1:0] max_shadow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_shadow_reg <= hbud_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_shadow_reg <= cfg_wr_data;
        end
    end

    a_payload_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_end) |->
            (m_frame_status == hbud_pkg::ST_OK && m_frame_length == '0))
        else $error("payload transaction carries frame-end fields");

    a_length_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> (m_frame_length <= max_shadow_reg))
        else $error("frame length above configured maximum");

    a_oversize_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end && m_frame_status == hbud_pkg::ST_OVERSIZE) |->
            (m_frame_length == max_shadow_reg))
        else $error("oversize frame does not report full length");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |->
            (m_frame_status == hbud_pkg::ST_OK || m_frame_status == hbud_pkg::ST_BAD_ESC
             || m_frame_status == hbud_pkg::ST_OVERSIZE))
        else $error("illegal frame status");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_payload_byte) && $stable(m_frame_end)
             && $stable(m_frame_status) && $stable(m_frame_length)))
        else $error("stalled result transaction changed");

endmodule

bind hdlc_byte_unstuff_deframer_top hbud_checker u_hbud_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_payload_byte (m_payload_byte),
    .m_frame_end    (m_frame_end),
    .m_frame_status (m_frame_status),
    .m_frame_length (m_frame_length)
);

// ===== sim/hdlc_byte_unstuff_deframer_checker.sv =====
// Scoreboard for the HDLC deframer: tracks line bytes and limit writes, predicts results, compares.
module hdlc_byte_unstuff_deframer_checker
    import hbud_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [BYTE_W-1:0]   s_line_byte,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [BYTE_W-1:0]   m_payload_byte,
    input  logic                m_frame_end,
    input  logic [STATUS_W-1:0] m_frame_status,
    input  logic [LEN_W-1:0]    m_frame_length,
    output int                  fail_count,
    output int                  outstanding
);

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        status_t           frame_status;
        logic [LEN_W-1:0]  frame_length;
    } frame_result_t;

    // shadow of the deframer state
    logic [LEN_W-1:0]   max_len;
    logic               in_frame;
    logic               esc_pending;
    logic [COUNT_W-1:0] payload_count;

    frame_result_t expected_results [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic void close_frame(input status_t st);
        logic [LEN_W-1:0] delivered;
        delivered = (payload_count < max_len) ? payload_count[LEN_W-1:0] : max_len;
        expected_results.push_back('{'0, 1'b1, st, delivered});
        in_frame      = 1'b0;
        esc_pending   = 1'b0;
        payload_count = '0;
    endfunction

    function automatic void decode_line_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] data;
        logic              deliver;
        if (b == FLAG_BYTE) begin
            if (!in_frame) begin
                in_frame      = 1'b1;
                esc_pending   = 1'b0;
                payload_count = '0;
            end else if (esc_pending) begin
                close_frame(ST_BAD_ESC);
            end else begin
                close_frame((payload_count > max_len) ? ST_OVERSIZE : ST_OK);
            end
        end else if (in_frame) begin
            if (b == ESC_BYTE) begin
                if (esc_pending)
                    close_frame(ST_BAD_ESC);
                else
                    esc_pending = 1'b1;
            end else begin
                data        = esc_pending ? (b ^ ESC_XOR) : b;
                esc_pending = 1'b0;
                deliver     = payload_count < max_len;
                if (payload_count != COUNT_MAX)
                    payload_count = payload_count + 1'b1;
                if (deliver)
                    expected_results.push_back('{data, 1'b0, ST_OK, '0});
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        frame_result_t got;
        frame_result_t want;
        if (!aresetn) begin
            max_len       = MAX_LEN_RESET;
            in_frame      = 1'b0;
            esc_pending   = 1'b0;
            payload_count = '0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_payload_byte, m_frame_end, status_t'(m_frame_status), m_frame_length};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: byte %h end %b status %0d length %0d",
                             $time, got.payload_byte, got.frame_end, got.frame_status,
                             got.frame_length);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display("%0t: mismatch: expected %h %b %0d %0d, got %h %b %0d %0d",
                                 $time, want.payload_byte, want.frame_end, want.frame_status,
                                 want.frame_length, got.payload_byte, got.frame_end,
                                 got.frame_status, got.frame_length);
                    end
                end
            end
            if (cfg_wr_en)
                max_len = cfg_wr_data;
            if (s_valid && s_ready)
                decode_line_byte(s_line_byte);
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== sim/hdlc_byte_unstuff_deframer_top_test.sv =====
// Testbench top for the HDLC deframer: clock, reset, line byte stimulus, result sink, verdict.
module hdlc_byte_unstuff_deframer_top_test;
    import hbud_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [LEN_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_line_byte;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_payload_byte;
    logic                m_frame_end;
    logic [STATUS_W-1:0] m_frame_status;
    logic [LEN_W-1:0]    m_frame_length;

    int fail_count;
    int outstanding;

    // Idle controls, set per phase. 0 means no idling on that side.
    int tx_max_gap;
    int rx_max_stall;
    // Set by stimulus to ask the sink for one long hold-off of m_ready.
    bit hold_request;
    int bytes_sent;

    // Directed opener at the reset limit (65535):
    //   bytes outside a frame (data, escape) are dropped,
    //   two adjacent flags give an empty ok frame,
    //   escaped flag char, escaped escape char and an escaped ordinary byte,
    //   an escaped flag ends the frame with bad escape, then a dropped byte,
    //   a double escape ends the frame with bad escape.
    localparam logic [BYTE_W-1:0] OPENING_BYTES [23] = '{
        8'h00, ESC_BYTE, 8'hFF,
        FLAG_BYTE, FLAG_BYTE,
        FLAG_BYTE, 8'h00, 8'hFF, ESC_BYTE, 8'h5E, ESC_BYTE, 8'h5D, ESC_BYTE, 8'h41, FLAG_BYTE,
        FLAG_BYTE, 8'h11, ESC_BYTE, FLAG_BYTE,
        8'h22,
        FLAG_BYTE, ESC_BYTE, ESC_BYTE
    };

    // At limit 1: an oversize frame, then a bad escape on an oversize frame
    // (bad escape wins).
    localparam logic [BYTE_W-1:0] OVERSIZE_BYTES [9] = '{
        FLAG_BYTE, 8'h01, 8'h02, FLAG_BYTE,
        FLAG_BYTE, 8'h01, 8'h02, ESC_BYTE, FLAG_BYTE
    };

    // Limit settings for the random phases; a random one follows the list.
    localparam logic [LEN_W-1:0] LIMIT_STEPS [5] = '{16'd0, 16'd1, 16'd3, 16'd12, 16'hFFFF};

    hdlc_byte_unstuff_deframer_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_line_byte    (s_line_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_status (m_frame_status),
        .m_frame_length (m_frame_length)
    );

    hdlc_byte_unstuff_deframer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_line_byte    (s_line_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_status (m_frame_status),
        .m_frame_length (m_frame_length),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(8 * 200000);
        $display("Simulation FAILED");
        $finish;
    end

    // One line byte transaction. Called at a falling edge, returns at the
    // falling edge after the byte was taken. valid is only lowered when a gap
    // is drawn, so back-to-back bytes keep it high without a glitch.
    task automatic send_line_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_line_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Well-formed frame: flags around len payload bytes. Flag and escape
    // values are always escaped; ordinary bytes sometimes are.
    task automatic send_frame(input int len);
        logic [BYTE_W-1:0] b;
        send_line_byte(FLAG_BYTE);
        for (int i = 0; i < len; i++) begin
            b = BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                b = ($urandom_range(0, 1) == 1) ? FLAG_BYTE : ESC_BYTE;
            if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 7) == 0) begin
                send_line_byte(ESC_BYTE);
                send_line_byte(b ^ ESC_XOR);
            end else begin
                send_line_byte(b);
            end
        end
        send_line_byte(FLAG_BYTE);
    endtask

    // Stop offering and wait until every predicted result has come out, then
    // let the pipeline settle for transactions that make no result.
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result sink: draws a stall after every accepted result; a hold-off
    // request overrides it for a long stretch so the block backs up.
    initial begin : sink
        int rx_stall;
        int hold_left;
        rx_stall  = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                rx_stall = $urandom_range(0, rx_max_stall);
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = 150;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int goal;
        int pick;
        logic [LEN_W-1:0] limit;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_line_byte  = '0;
        tx_max_gap   = 9;
        rx_max_stall = 9;
        hold_request = 1'b0;
        bytes_sent   = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, reset limit first
        foreach (OPENING_BYTES[i])
            send_line_byte(OPENING_BYTES[i]);
        drain_results(4);
        write_max_len(16'd1);
        foreach (OVERSIZE_BYTES[i])
            send_line_byte(OVERSIZE_BYTES[i]);

        // random phases, one limit each
        goal = bytes_sent;
        for (int p = 0; p < 6; p++) begin
            drain_results(4);
            limit = (p < 5) ? LIMIT_STEPS[p] : LEN_W'($urandom_range(1, 40));
            write_max_len(limit);
            tx_max_gap   = (p == 1 || p == 4) ? 0 : 9;
            rx_max_stall = (p == 2 || p == 4) ? 0 : 9;
            // long sink hold-off while bytes keep coming
            if (p == 2 || p == 4)
                hold_request = 1'b1;
            goal += 65;
            while (bytes_sent < goal) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    // line noise, may open a frame by accident
                    repeat ($urandom_range(1, 3))
                        send_line_byte(BYTE_W'($urandom_range(0, 255)));
                end else if (pick == 1) begin
                    // frame broken by an escaped flag or a double escape
                    send_line_byte(FLAG_BYTE);
                    repeat ($urandom_range(0, 6))
                        send_line_byte(BYTE_W'($urandom_range(0, 255)) & 8'hDF);
                    send_line_byte(ESC_BYTE);
                    send_line_byte(($urandom_range(0, 1) == 1) ? FLAG_BYTE : ESC_BYTE);
                end else begin
                    send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(0, 12));
                end
                // now and then the sender waits for all results
                if ($urandom_range(0, 24) == 0)
                    drain_results(0);
            end
        end

        drain_results(8);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
